// ----- rtl/assert_macros.svh -----
// Assertion helpers; they expect clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define CHK_SAME(name, trig, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define CHK_NEXT(name, trig, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/sbr_pkg.sv -----
`timescale 1ns / 1ps

package sbr_pkg;

  // Width of the visible pending count
  localparam int CNT_W = 13;

  // Item modes; any other code acts as a drain tick
  localparam logic [1:0] MODE_DATA = 2'd0;
  localparam logic [1:0] MODE_END  = 2'd1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [63:0]      stream_index;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] writer_space;
  } in_item_t;

  typedef struct packed {
    logic             has_byte;
    logic [7:0]       out_byte;
    logic             stream_closed;
    logic [CNT_W-1:0] pending_count;
  } out_item_t;

  // One ring slot: valid mark and stored byte
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } ring_entry_t;

  // Write request toward the ring
  typedef struct packed {
    logic        en;
    ring_entry_t entry;
  } ring_wr_t;

endpackage

// ----- rtl/sbr_ring.sv -----
`timescale 1ns / 1ps

module sbr_ring #(
  parameter int CAPACITY = 4096,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                clk,
  input  logic [AW-1:0]       wr_addr,
  input  sbr_pkg::ring_wr_t   wr,
  input  logic [AW-1:0]       rd_addr,
  output sbr_pkg::ring_entry_t rd_q
);
  import sbr_pkg::*;

  ring_entry_t mem [CAPACITY];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.entry;
    end
    rd_q <= mem[rd_addr];
  end

endmodule

// ----- rtl/stream_byte_reassembler.sv -----
`timescale 1ns / 1ps
// A result is registered in the close step, after the gap, address, store and deliver steps.
// Items are taken one at a time; item_stall stays high while one runs the ring access sequence
//   (index gap, slot read, store write plus head read, deliver write, close test).
// The result register lets the next item enter while a result waits.
// Reset: synchronous; a clearing pass over all CAPACITY slots zeroes the valid marks,
//   with item_stall high until it ends.
module stream_byte_reassembler #(
  parameter int CAPACITY = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  sbr_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output sbr_pkg::out_item_t result
);
  import sbr_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_GAP     = 3'd2;
  localparam logic [2:0] S_ADDR    = 3'd3;
  localparam logic [2:0] S_STORE   = 3'd4;
  localparam logic [2:0] S_DELIVER = 3'd5;
  localparam logic [2:0] S_CLOSE   = 3'd6;

  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  logic [63:0]   next_expected;
  logic [AW-1:0] next_slot;
  logic [CW-1:0] pending;
  logic          end_known;
  logic [63:0]   end_position;
  logic          closed;

  in_item_t      item_q;
  logic [63:0]   gap;
  logic          behind;
  logic          past_end;
  logic [AW-1:0] slot_q;
  logic          store_ok;
  logic          stored;
  logic          del_has;
  logic [7:0]    del_byte;

  logic [64:0]   gap_wide;
  logic [AW:0]   slot_sum;
  logic [AW:0]   slot_wrap;
  logic          in_win;
  logic [AW-1:0] next_slot_inc;
  ring_entry_t   rd_q;
  ring_entry_t   head;
  logic          deliver;
  logic          do_store;
  logic          closed_next;
  logic          result_free;
  logic [CW+CNT_W-1:0] pend_wide;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  ring_wr_t      wr;

  sbr_ring #(.CAPACITY(CAPACITY)) u_ring (
    .clk     (clk),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_q    (rd_q)
  );

  assign item_stall  = (state != S_IDLE);
  assign result_free = !result_valid || !result_stall;

  // Distance of the byte from the head; top bit is the borrow
  assign gap_wide = {1'b0, item_q.stream_index} - {1'b0, next_expected};

  // Ring slot of an in-window byte: head slot plus gap, wrapped once
  assign slot_sum  = {1'b0, next_slot} + {1'b0, gap[AW-1:0]};
  assign slot_wrap = (slot_sum >= (AW+1)'(CAPACITY)) ? slot_sum - (AW+1)'(CAPACITY)
                                                     : slot_sum;
  assign in_win = (gap < {{(64-CNT_W){1'b0}}, item_q.writer_space}) &&
                  (gap < 64'(CAPACITY));

  assign next_slot_inc = (next_slot == AW'(CAPACITY - 1)) ? '0 : next_slot + 1'b1;

  // Forward the byte stored this item when it sits at the head slot
  assign head = (stored && (slot_q == next_slot))
              ? ring_entry_t'{valid: 1'b1, data: item_q.data_byte}
              : rd_q;
  assign deliver  = (item_q.writer_space != '0) && head.valid;
  assign do_store = store_ok && !rd_q.valid;

  assign closed_next = closed || (end_known && (next_expected >= end_position));
  assign pend_wide   = {{CNT_W{1'b0}}, pending};

  // Ring port steering
  always_comb begin
    rd_addr  = next_slot;
    wr_addr  = next_slot;
    wr.en    = 1'b0;
    wr.entry = '{valid: 1'b0, data: 8'd0};
    case (state)
      S_CLEAR: begin
        wr_addr = clr_addr;
        wr.en   = 1'b1;
      end
      S_ADDR: begin
        rd_addr = slot_wrap[AW-1:0];
      end
      S_STORE: begin
        wr_addr  = slot_q;
        wr.en    = do_store;
        wr.entry = '{valid: 1'b1, data: item_q.data_byte};
      end
      S_DELIVER: begin
        wr.en = deliver;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      next_expected <= '0;
      next_slot     <= '0;
      pending       <= '0;
      end_known     <= 1'b0;
      end_position  <= '0;
      closed        <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      // raise the result beat at close, drop it once taken
      if (state == S_CLOSE && result_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            state <= S_GAP;
          end
        end
        S_GAP: begin
          state <= S_ADDR;
        end
        S_ADDR: begin
          state <= S_STORE;
        end
        S_STORE: begin
          if (do_store) begin
            pending <= pending + 1'b1;
          end
          if ((item_q.mode == MODE_END) && !closed) begin
            end_known    <= 1'b1;
            end_position <= item_q.stream_index;
          end
          state <= S_DELIVER;
        end
        S_DELIVER: begin
          if (deliver) begin
            pending       <= pending - 1'b1;
            next_expected <= next_expected + 64'd1;
            next_slot     <= next_slot_inc;
          end
          state <= S_CLOSE;
        end
        S_CLOSE: begin
          // hold here until the result register frees up
          if (result_free) begin
            closed <= closed_next;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      item_q <= item;
    end
    if (state == S_GAP) begin
      gap      <= gap_wide[63:0];
      behind   <= gap_wide[64];
      past_end <= (item_q.stream_index >= end_position);
    end
    if (state == S_ADDR) begin
      slot_q   <= slot_wrap[AW-1:0];
      store_ok <= (item_q.mode == MODE_DATA) && !behind && in_win &&
                  !(end_known && past_end);
    end
    if (state == S_STORE) begin
      stored <= do_store;
    end
    if (state == S_DELIVER) begin
      del_has  <= deliver;
      del_byte <= deliver ? head.data : 8'd0;
    end
    if (state == S_CLOSE && result_free) begin
      result.has_byte      <= del_has;
      result.out_byte      <= del_byte;
      result.stream_closed <= closed_next;
      result.pending_count <= pend_wide[CNT_W-1:0];
    end
  end

  `CHK_SAME(a_pending_cap, 1'b1, pending <= CW'(CAPACITY), "pending count beyond capacity")
  `CHK_NEXT(a_head_hold, state != S_DELIVER, next_expected == $past(next_expected), "head moved outside delivery")
  `CHK_NEXT(a_closed_sticky, closed, closed, "stream reopened after close")
  `CHK_NEXT(a_byte_needs_space, state == S_DELIVER && item_q.writer_space == '0, !del_has, "byte delivered with writer full")

endmodule
